// File: sv/chacha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package chacha_pkg;

   localparam int ROUND_COUNT = 20;
   localparam int ROUND_W     = $clog2(ROUND_COUNT + 1);

   localparam int STATE_WORDS = 16;
   localparam int BLOCK_BYTES = 64;
   localparam int WORD_BYTES  = 8;
   localparam int BLOCK_WORDS = BLOCK_BYTES / WORD_BYTES;
   localparam int WORD_IDX_W  = $clog2(BLOCK_WORDS);

   localparam int JOBQ_DEPTH = 2;
   localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
   localparam int JOBQ_CNT_W = $clog2(JOBQ_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART_0   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART_1   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART_2   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_PART_3   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_NONCE_VALUE  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_COUNTER_START = 3'd5;

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   typedef logic [31:0] word_type;
   typedef word_type [STATE_WORDS-1:0] state_type;

   typedef struct packed {
      logic [63:0] key_part_0;
      logic [63:0] key_part_1;
      logic [63:0] key_part_2;
      logic [63:0] key_part_3;
      logic [63:0] nonce_value;
   } cipher_cfg_type;

   typedef struct packed {
      logic [63:0] counter;
      logic [6:0]  wanted;
   } job_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
      word_type d;
   } quad_type;

   function automatic quad_type quarter(word_type a_in, word_type b_in,
                                        word_type c_in, word_type d_in);
      quad_type q;
      q.a = a_in;
      q.b = b_in;
      q.c = c_in;
      q.d = d_in;
      q.a = q.a + q.b;
      q.d = q.d ^ q.a;
      q.d = {q.d[15:0], q.d[31:16]};
      q.c = q.c + q.d;
      q.b = q.b ^ q.c;
      q.b = {q.b[19:0], q.b[31:20]};
      q.a = q.a + q.b;
      q.d = q.d ^ q.a;
      q.d = {q.d[23:0], q.d[31:24]};
      q.c = q.c + q.d;
      q.b = q.b ^ q.c;
      q.b = {q.b[24:0], q.b[31:25]};
      return q;
   endfunction

   function automatic state_type chacha_round(state_type s, logic diag);
      state_type r;
      quad_type  q;
      int        ib;
      int        ic;
      int        id;
      r = s;
      for (int i = 0; i < 4; i++) begin
         ib = diag ? 4 + ((i + 1) & 3) : 4 + i;
         ic = diag ? 8 + ((i + 2) & 3) : 8 + i;
         id = diag ? 12 + ((i + 3) & 3) : 12 + i;
         q = quarter(s[i], s[ib], s[ic], s[id]);
         r[i]  = q.a;
         r[ib] = q.b;
         r[ic] = q.c;
         r[id] = q.d;
      end
      return r;
   endfunction

   function automatic state_type build_init(cipher_cfg_type cfg, logic [63:0] counter);
      state_type s;
      s[0]  = SIGMA_0;
      s[1]  = SIGMA_1;
      s[2]  = SIGMA_2;
      s[3]  = SIGMA_3;
      s[4]  = cfg.key_part_0[31:0];
      s[5]  = cfg.key_part_0[63:32];
      s[6]  = cfg.key_part_1[31:0];
      s[7]  = cfg.key_part_1[63:32];
      s[8]  = cfg.key_part_2[31:0];
      s[9]  = cfg.key_part_2[63:32];
      s[10] = cfg.key_part_3[31:0];
      s[11] = cfg.key_part_3[63:32];
      s[12] = counter[31:0];
      s[13] = counter[63:32];
      s[14] = cfg.nonce_value[31:0];
      s[15] = cfg.nonce_value[63:32];
      return s;
   endfunction

endpackage
`default_nettype wire

// File: sv/chacha_front.sv
`timescale 1ns / 1ps
`default_nettype none
module chacha_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [chacha_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                       csr_data,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_restart,
   input  logic [6:0]                        req_bytes_wanted,
   input  logic                              jobq_full,
   output logic                              jobq_push,
   output chacha_pkg::job_type               jobq_job,
   output chacha_pkg::cipher_cfg_type        cfg
);
   import chacha_pkg::*;

   cipher_cfg_type cfg_ff;
   cipher_cfg_type cfg_in;
   logic [63:0]    counter_start_ff;
   logic [63:0]    counter_start_in;
   logic [63:0]    block_counter_ff;
   logic [63:0]    block_counter_in;
   logic [63:0]    base_counter;
   logic [6:0]     wanted_sat;
   logic           accept;
   logic           has_block;

   assign accept       = req_push && !jobq_full;
   assign base_counter = req_restart ? counter_start_ff : block_counter_ff;
   assign wanted_sat   = req_bytes_wanted[6] ? 7'(BLOCK_BYTES) : req_bytes_wanted;
   assign has_block    = req_bytes_wanted != 7'd0;

   always_comb begin
      cfg_in           = cfg_ff;
      counter_start_in = counter_start_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_PART_0:    cfg_in.key_part_0  = csr_data;
            CSR_KEY_PART_1:    cfg_in.key_part_1  = csr_data;
            CSR_KEY_PART_2:    cfg_in.key_part_2  = csr_data;
            CSR_KEY_PART_3:    cfg_in.key_part_3  = csr_data;
            CSR_NONCE_VALUE:   cfg_in.nonce_value = csr_data;
            CSR_COUNTER_START: counter_start_in   = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      block_counter_in = block_counter_ff;
      if (accept) begin
         block_counter_in = has_block ? base_counter + 64'd1 : base_counter;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff           <= '0;
         counter_start_ff <= '0;
         block_counter_ff <= '0;
      end else begin
         cfg_ff           <= cfg_in;
         counter_start_ff <= counter_start_in;
         block_counter_ff <= block_counter_in;
      end
   end

   assign req_full         = jobq_full;
   assign jobq_push        = accept && has_block;
   assign jobq_job.counter = base_counter;
   assign jobq_job.wanted  = wanted_sat;
   assign cfg              = cfg_ff;

endmodule
`default_nettype wire

// File: sv/chacha_jobq.sv
`timescale 1ns / 1ps
`default_nettype none
module chacha_jobq (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  chacha_pkg::job_type push_job,
   output logic                full,
   output logic                valid,
   input  logic                pop,
   output chacha_pkg::job_type head_job
);
   import chacha_pkg::*;

   job_type                slot_ff [JOBQ_DEPTH];
   logic [JOBQ_PTR_W-1:0]  wr_ptr_ff;
   logic [JOBQ_PTR_W-1:0]  wr_ptr_in;
   logic [JOBQ_PTR_W-1:0]  rd_ptr_ff;
   logic [JOBQ_PTR_W-1:0]  rd_ptr_in;
   logic [JOBQ_CNT_W-1:0]  count_ff;
   logic [JOBQ_CNT_W-1:0]  count_in;
   logic                   do_push;
   logic                   do_pop;

   assign full     = count_ff == JOBQ_CNT_W'(JOBQ_DEPTH);
   assign valid    = count_ff != '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign head_job = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/chacha_core.sv
`timescale 1ns / 1ps
`default_nettype none
module chacha_core (
   input  logic                       clock,
   input  logic                       reset,
   input  chacha_pkg::cipher_cfg_type cfg,
   input  logic                       job_valid,
   input  chacha_pkg::job_type        job,
   output logic                       job_pop,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [63:0]                rsp_keystream_word,
   output logic [3:0]                 rsp_valid_bytes,
   output logic                       rsp_last_word
);
   import chacha_pkg::*;

   logic                                busy_ff;
   logic                                busy_in;
   logic [ROUND_W-1:0]                  round_ff;
   logic [ROUND_W-1:0]                  round_in;
   state_type                           x_ff;
   state_type                           x_in;
   logic [63:0]                         counter_ff;
   logic [6:0]                          wanted_ff;
   logic                                out_valid_ff;
   logic                                out_valid_in;
   logic [WORD_IDX_W-1:0]               out_idx_ff;
   logic [WORD_IDX_W-1:0]               out_idx_in;
   logic [6:0]                          out_wanted_ff;
   logic [BLOCK_WORDS-1:0][63:0]        words_ff;
   logic [BLOCK_WORDS-1:0][63:0]        words_in;

   state_type   init_job;
   state_type   init_run;
   state_type   sum;
   logic        start;
   logic        rounds_done;
   logic        load_out;
   logic        out_last;
   logic        out_take;
   logic        out_free;
   logic [6:0]  wanted_m1;

   assign init_job    = build_init(cfg, job.counter);
   assign init_run    = build_init(cfg, counter_ff);
   assign start       = !busy_ff && job_valid;
   assign rounds_done = busy_ff && (round_ff == ROUND_W'(ROUND_COUNT));

   assign wanted_m1 = out_wanted_ff - 7'd1;
   assign out_last  = out_idx_ff == wanted_m1[5:3];
   assign out_take  = rsp_pop && out_valid_ff;
   assign out_free  = !out_valid_ff || (out_take && out_last);
   assign load_out  = rounds_done && out_free;

   always_comb begin
      for (int i = 0; i < STATE_WORDS; i++) begin
         sum[i] = x_ff[i] + init_run[i];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      round_in = round_ff;
      x_in     = x_ff;
      if (start) begin
         busy_in  = 1'b1;
         round_in = '0;
         x_in     = init_job;
      end else if (busy_ff && !rounds_done) begin
         round_in = round_ff + 1'b1;
         x_in     = chacha_round(x_ff, round_ff[0]);
      end else if (load_out) begin
         busy_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_idx_in   = out_idx_ff;
      words_in     = words_ff;
      if (load_out) begin
         out_valid_in = 1'b1;
         out_idx_in   = '0;
         for (int k = 0; k < BLOCK_WORDS; k++) begin
            words_in[k] = {sum[2 * k + 1], sum[2 * k]};
         end
      end else if (out_take) begin
         if (out_last) begin
            out_valid_in = 1'b0;
         end else begin
            out_idx_in = out_idx_ff + 1'b1;
         end
         for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
            words_in[k] = words_ff[k + 1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         round_ff     <= '0;
         out_valid_ff <= 1'b0;
         out_idx_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         round_ff     <= round_in;
         out_valid_ff <= out_valid_in;
         out_idx_ff   <= out_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      words_ff <= words_in;
      if (start) begin
         counter_ff <= job.counter;
         wanted_ff  <= job.wanted;
      end
      if (load_out) begin
         out_wanted_ff <= wanted_ff;
      end
   end

   assign job_pop            = start;
   assign rsp_empty          = !out_valid_ff;
   assign rsp_keystream_word = words_ff[0];
   assign rsp_last_word      = out_last;
   assign rsp_valid_bytes    = out_last ? ({1'b0, wanted_m1[2:0]} + 4'd1)
                                        : 4'(WORD_BYTES);

endmodule
`default_nettype wire

// File: sv/chacha20_keystream_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel   Ports                                         Handshake
// request   req_restart, req_bytes_wanted                 req_push && !req_full
// response  rsp_keystream_word, rsp_valid_bytes,          rsp_pop && !rsp_empty
//           rsp_last_word
// config    csr_index, csr_data                           csr_write
//
// One round per cycle in the core: a block goes through load, rounds and final
// add, and then yields 1 to 8 response words.
// The word buffer drains while the next block runs, so the core can start the
// next request before the words of the last one have been read.
// Requests asking for zero bytes yield no words.
// Synchronous reset clears key, nonce, start value and block counter to zero.
// A full two-entry request queue raises req_full; an unread word stalls the core.
module chacha20_keystream_generator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write,
   input  logic [chacha_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [63:0]                       csr_data,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic                              req_restart,
   input  logic [6:0]                        req_bytes_wanted,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [63:0]                       rsp_keystream_word,
   output logic [3:0]                        rsp_valid_bytes,
   output logic                              rsp_last_word
);
   import chacha_pkg::*;

   cipher_cfg_type cfg;
   job_type        push_job;
   job_type        head_job;
   logic           jobq_push;
   logic           jobq_full;
   logic           jobq_valid;
   logic           jobq_pop;

   chacha_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_restart      (req_restart),
      .req_bytes_wanted (req_bytes_wanted),
      .jobq_full        (jobq_full),
      .jobq_push        (jobq_push),
      .jobq_job         (push_job),
      .cfg              (cfg)
   );

   chacha_jobq u_jobq (
      .clock    (clock),
      .reset    (reset),
      .push     (jobq_push),
      .push_job (push_job),
      .full     (jobq_full),
      .valid    (jobq_valid),
      .pop      (jobq_pop),
      .head_job (head_job)
   );

   chacha_core u_core (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .job_valid          (jobq_valid),
      .job                (head_job),
      .job_pop            (jobq_pop),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_valid_bytes    (rsp_valid_bytes),
      .rsp_last_word      (rsp_last_word)
   );

endmodule
`default_nettype wire

// File: dv/tb_chacha20_keystream_generator.sv
`timescale 1ns / 1ps
module tb_chacha20_keystream_generator;
   import chacha_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 2 * (ROUND_COUNT + 2) + 8;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_ITEMS  = 64;

   typedef struct packed {
      logic [63:0] word;
      logic [3:0]  valid;
      logic        last;
   } keystream_beat_type;

   class keystream_scoreboard;
      logic [63:0]        key_part[4];
      logic [63:0]        nonce;
      logic [63:0]        start_count;
      logic [63:0]        block_count;
      word_type           mix_state[16];
      keystream_beat_type expected_q[$];
      int                 errors;
      int                 requests_taken;
      int                 blocks_made;
      int                 words_checked;

      function new();
         foreach (key_part[i]) key_part[i] = '0;
         nonce          = '0;
         start_count    = '0;
         block_count    = '0;
         errors         = 0;
         requests_taken = 0;
         blocks_made    = 0;
         words_checked  = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [63:0] data);
         case (idx)
            CSR_KEY_PART_0:    key_part[0] = data;
            CSR_KEY_PART_1:    key_part[1] = data;
            CSR_KEY_PART_2:    key_part[2] = data;
            CSR_KEY_PART_3:    key_part[3] = data;
            CSR_NONCE_VALUE:   nonce = data;
            CSR_COUNTER_START: start_count = data;
            default: ;
         endcase
      endfunction

      function word_type rotl(word_type v, int s);
         return (v << s) | (v >> (32 - s));
      endfunction

      function void mix(int a, int b, int c, int d);
         mix_state[a] = mix_state[a] + mix_state[b];
         mix_state[d] = rotl(mix_state[d] ^ mix_state[a], 16);
         mix_state[c] = mix_state[c] + mix_state[d];
         mix_state[b] = rotl(mix_state[b] ^ mix_state[c], 12);
         mix_state[a] = mix_state[a] + mix_state[b];
         mix_state[d] = rotl(mix_state[d] ^ mix_state[a], 8);
         mix_state[c] = mix_state[c] + mix_state[d];
         mix_state[b] = rotl(mix_state[b] ^ mix_state[c], 7);
      endfunction

      function void note_request(logic restart, logic [6:0] wanted);
         word_type           seed_words[16];
         int                 count;
         int                 nwords;
         keystream_beat_type beat;
         requests_taken++;
         if (restart) block_count = start_count;
         if (wanted == 0) return;
         count = (wanted > 64) ? 64 : int'(wanted);
         seed_words[0] = SIGMA_0;
         seed_words[1] = SIGMA_1;
         seed_words[2] = SIGMA_2;
         seed_words[3] = SIGMA_3;
         for (int i = 0; i < 4; i++) begin
            seed_words[4 + 2 * i] = key_part[i][31:0];
            seed_words[5 + 2 * i] = key_part[i][63:32];
         end
         seed_words[12] = block_count[31:0];
         seed_words[13] = block_count[63:32];
         seed_words[14] = nonce[31:0];
         seed_words[15] = nonce[63:32];
         mix_state = seed_words;
         for (int r = 0; r < ROUND_COUNT / 2; r++) begin
            mix(0, 4, 8, 12);
            mix(1, 5, 9, 13);
            mix(2, 6, 10, 14);
            mix(3, 7, 11, 15);
            mix(0, 5, 10, 15);
            mix(1, 6, 11, 12);
            mix(2, 7, 8, 13);
            mix(3, 4, 9, 14);
         end
         for (int i = 0; i < 16; i++) mix_state[i] = mix_state[i] + seed_words[i];
         block_count = block_count + 64'd1;
         blocks_made++;
         nwords = (count + 7) / 8;
         for (int k = 0; k < nwords; k++) begin
            beat.word  = {mix_state[2 * k + 1], mix_state[2 * k]};
            beat.last  = (k == nwords - 1);
            beat.valid = beat.last ? 4'(count - 8 * k) : 4'd8;
            expected_q.push_back(beat);
         end
      endfunction

      task report(string msg);
         errors++;
         $display("MISMATCH @%0t: %s", $realtime, msg);
      endtask

      task check_word(logic [63:0] word, logic [3:0] valid, logic last);
         keystream_beat_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected word %h", word));
            return;
         end
         want = expected_q.pop_front();
         words_checked++;
         if (word !== want.word)
            report($sformatf("keystream_word %h, expected %h", word, want.word));
         if (valid !== want.valid)
            report($sformatf("valid_bytes %0d, expected %0d", valid, want.valid));
         if (last !== want.last)
            report($sformatf("last_word %b, expected %b", last, want.last));
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [63:0]            csr_data;
   logic                   req_push;
   logic                   req_full;
   logic                   req_restart;
   logic [6:0]             req_bytes_wanted;
   logic                   rsp_empty;
   logic                   rsp_pop;
   logic [63:0]            rsp_keystream_word;
   logic [3:0]             rsp_valid_bytes;
   logic                   rsp_last_word;

   keystream_scoreboard sb;
   bit                  quiet = 1'b0;
   bit                  hold_request = 1'b0;
   int                  holds_done = 0;
   int                  cycle_count = 0;

   chacha20_keystream_generator u_top (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_write),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_restart        (req_restart),
      .req_bytes_wanted   (req_bytes_wanted),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_keystream_word (rsp_keystream_word),
      .rsp_valid_bytes    (rsp_valid_bytes),
      .rsp_last_word      (rsp_last_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
   end

   // response side: random pop bursts plus one long hold-off
   initial begin
      int  stall_left;
      logic next_pop;
      stall_left = 0;
      rsp_pop = 1'b0;
      wait (reset === 1'b0);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_pop = 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            holds_done++;
         end
         if (stall_left > 0) begin
            next_pop = 1'b0;
            stall_left--;
         end else begin
            next_pop = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 8);
         end
         rsp_pop = next_pop;
         @(posedge clock);
         if (rsp_pop && rsp_empty === 1'b0)
            sb.check_word(rsp_keystream_word, rsp_valid_bytes, rsp_last_word);
      end
   end

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, logic [63:0] data);
      @(negedge clock);
      csr_write = 1'b1;
      csr_index = idx;
      csr_data  = data;
      @(posedge clock);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_write = 1'b0;
   endtask

   task automatic push_request(logic restart, logic [6:0] wanted);
      @(negedge clock);
      req_push         = 1'b1;
      req_restart      = restart;
      req_bytes_wanted = wanted;
      @(posedge clock);
      while (req_full !== 1'b0) @(posedge clock);
      sb.note_request(restart, wanted);
   endtask

   task automatic idle_sender(int n);
      @(negedge clock);
      req_push = 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   // drop push, drain every expected word, then idle a while
   task automatic settle();
      idle_sender(1);
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 64'd0;
         1: return '1;
         2: return 64'hFFFF_FFFF_FFFF_FFFE;
         3: return 64'h0000_0000_FFFF_FFFF;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   task automatic shuffle_settings();
      if ($urandom_range(0, 3) != 0) write_reg(CSR_KEY_PART_0, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_KEY_PART_1, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_KEY_PART_2, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_KEY_PART_3, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_NONCE_VALUE, pick_value());
      if ($urandom_range(0, 3) != 0) write_reg(CSR_COUNTER_START, pick_value());
   endtask

   task automatic send_random();
      logic       restart;
      logic [6:0] wanted;
      int         pick;
      restart = ($urandom_range(0, 7) == 0);
      pick    = $urandom_range(0, 19);
      if (pick == 0) wanted = 7'd0;
      else if (pick == 1) wanted = 7'($urandom_range(65, 127));
      else if (pick < 6) wanted = 7'd64;
      else wanted = 7'($urandom_range(1, 64));
      push_request(restart, wanted);
      if (!quiet && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 8));
   endtask

   initial begin
      csr_write        = 1'b0;
      csr_index        = CSR_KEY_PART_0;
      csr_data         = '0;
      req_push         = 1'b0;
      req_restart      = 1'b0;
      req_bytes_wanted = '0;
      sb = new();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset register values: size edges, zero and oversize requests
      push_request(1'b0, 7'd64);
      push_request(1'b0, 7'd1);
      push_request(1'b0, 7'd8);
      push_request(1'b0, 7'd9);
      push_request(1'b0, 7'd0);
      push_request(1'b1, 7'd0);
      push_request(1'b0, 7'd63);
      push_request(1'b0, 7'd65);
      push_request(1'b0, 7'd127);
      push_request(1'b1, 7'd64);
      push_request(1'b0, 7'd7);
      push_request(1'b0, 7'd57);
      push_request(1'b0, 7'd16);

      // all-ones registers: counter wraps to zero
      settle();
      write_reg(CSR_KEY_PART_0, '1);
      write_reg(CSR_KEY_PART_1, '1);
      write_reg(CSR_KEY_PART_2, '1);
      write_reg(CSR_KEY_PART_3, '1);
      write_reg(CSR_NONCE_VALUE, '1);
      write_reg(CSR_COUNTER_START, '1);
      push_request(1'b1, 7'd64);
      push_request(1'b0, 7'd64);
      push_request(1'b0, 7'd33);

      // carry from the low counter word into the high one
      settle();
      write_reg(CSR_KEY_PART_0, {$urandom, $urandom});
      write_reg(CSR_COUNTER_START, 64'h0000_0000_FFFF_FFFF);
      push_request(1'b1, 7'd64);
      push_request(1'b0, 7'd40);

      for (int p = 0; p < 6; p++) begin
         settle();
         shuffle_settings();
         if (p == 1) hold_request = 1'b1;
         if (p == 5) quiet = 1'b1;
         repeat (PHASE_ITEMS) send_random();
      end

      settle();
      $display("%0d requests, %0d blocks, %0d words checked over %0d cycles",
               sb.requests_taken, sb.blocks_made, sb.words_checked, cycle_count);
      $display("%0d long response hold-off(s), %0d mismatches", holds_done, sb.errors);
      if (sb.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// File: filelist.f
sv/chacha_pkg.sv
sv/chacha_front.sv
sv/chacha_jobq.sv
sv/chacha_core.sv
sv/chacha20_keystream_generator.sv
dv/tb_chacha20_keystream_generator.sv
